>>> design/shader_slot_cache_activator_top_assert.svh
// assertion macros for the shader slot cache activator
`ifndef SHADER_SLOT_CACHE_ACTIVATOR_TOP_ASSERT_SVH
`define SHADER_SLOT_CACHE_ACTIVATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SSCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SSCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ssca_pkg.sv
package ssca_pkg;

  localparam int unsigned DEF_CACHE_ENTRIES = 32;
  // program index is the low bits of the id; count kept a power of two
  localparam int unsigned SHADER_COUNT      = 64;
  localparam int unsigned SLOT_CAPACITY     = 136;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned CB_W     = 6;
  localparam int unsigned ADDR_W   = 8;
  localparam int unsigned USED_W   = 9;
  localparam int unsigned IDX_W    = $clog2(SHADER_COUNT);
  localparam int unsigned CUSTOM_BIT = 31;

  localparam logic [ID_W-1:0] RESET_ID = 32'h7fff_ffff;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_KEEP,
    CMD_FIXED,
    CMD_CUSTOM
  } ssca_cmd_e;

  typedef struct packed {
    ssca_cmd_e          op;
    logic [IDX_W-1:0]   idx;
    logic [SIZE_W-1:0]  size;
    logic [CB_W-1:0]    cb;
  } ssca_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ssca_q_stat_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
  } ssca_entry_t;

  typedef struct packed {
    logic              changed;
    logic              fixed_mode;
    logic              loaded_new;
    logic              flushed;
    logic [ADDR_W-1:0] slot_addr;
    logic              run_callback;
  } ssca_rsp_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SEARCH,
    B_DONE
  } ssca_back_e;

endpackage

>>> design/ssca_if.sv
interface ssca_req_if import ssca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   shader_id;
  logic [SIZE_W-1:0] shader_size;
  logic [CB_W-1:0]   callback_id;

  modport source (output valid, output shader_id, output shader_size, output callback_id,
                  input ready);
  modport sink   (input valid, input shader_id, input shader_size, input callback_id,
                  output ready);
endinterface

interface ssca_rsp_if import ssca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              changed;
  logic              fixed_mode;
  logic              loaded_new;
  logic              flushed;
  logic [ADDR_W-1:0] slot_addr;
  logic              run_callback;

  modport source (output valid, output changed, output fixed_mode, output loaded_new,
                  output flushed, output slot_addr, output run_callback, input ready);
  modport sink   (input valid, input changed, input fixed_mode, input loaded_new,
                  input flushed, input slot_addr, input run_callback, output ready);
endinterface

>>> design/ssca_queue.sv
module ssca_queue import ssca_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ssca_cmd_t    cmd_i,
  input  logic         pop_i,
  output ssca_cmd_t    cmd_o,
  output ssca_q_stat_t q_stat_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  ssca_cmd_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign q_stat_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign q_stat_o.empty = (cnt_q == '0);
  assign cmd_o          = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> design/ssca_front.sv
module ssca_front import ssca_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssca_req_if.sink     req_i,
  input  ssca_q_stat_t q_stat_i,
  output logic         push_o,
  output ssca_cmd_t    cmd_o
);

  logic [ID_W-1:0] active_id_q, active_id_d;

  assign req_i.ready = !q_stat_i.full;
  assign push_o      = req_i.valid && !q_stat_i.full;

  always_comb begin
    cmd_o.idx   = req_i.shader_id[IDX_W-1:0];
    cmd_o.size  = req_i.shader_size;
    cmd_o.cb    = req_i.callback_id;
    active_id_d = push_o ? req_i.shader_id : active_id_q;
    // a repeat of the active id wins over the custom bit
    if (req_i.shader_id == active_id_q) begin
      cmd_o.op = CMD_KEEP;
    end else if (req_i.shader_id[CUSTOM_BIT]) begin
      cmd_o.op = CMD_CUSTOM;
    end else begin
      cmd_o.op = CMD_FIXED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_id_q <= RESET_ID;
    end else begin
      active_id_q <= active_id_d;
    end
  end

endmodule

>>> design/ssca_back.sv
module ssca_back import ssca_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = DEF_CACHE_ENTRIES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ssca_q_stat_t q_stat_i,
  input  ssca_cmd_t    cmd_i,
  output logic         pop_o,
  ssca_rsp_if.source   rsp_o
);

  localparam int unsigned AW = $clog2(CACHE_ENTRIES);
  localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned SUM_W = USED_W + 1;

  ssca_entry_t       mem [CACHE_ENTRIES];
  ssca_entry_t       rdata_q;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  ssca_entry_t       wr_data;

  ssca_back_e        state_q, state_d;
  ssca_cmd_t         cmd_q, cmd_d;
  logic [CW-1:0]     s_q, s_d;
  logic              rd_vld_q, rd_vld_d;
  logic [CW-1:0]     count_q, count_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [CB_W-1:0]   cb_q, cb_d;
  logic              fixed_q, fixed_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  ssca_rsp_t         res_q, res_d;
  logic              out_vld_q, out_vld_d;
  ssca_rsp_t         out_q, out_d;

  logic              issue, hit, run_cb, flush;
  logic [CW-1:0]     base_cnt;
  logic [USED_W-1:0] base_used;

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.changed      = out_q.changed;
  assign rsp_o.fixed_mode   = out_q.fixed_mode;
  assign rsp_o.loaded_new   = out_q.loaded_new;
  assign rsp_o.flushed      = out_q.flushed;
  assign rsp_o.slot_addr    = out_q.slot_addr;
  assign rsp_o.run_callback = out_q.run_callback;

  // entry scan: one read per cycle, compare on the registered word
  assign issue   = (s_q < count_q);
  assign rd_addr = s_q[AW-1:0];
  assign hit     = rd_vld_q && (rdata_q.idx == cmd_q.idx);
  assign run_cb  = (cmd_q.cb != '0) && (cmd_q.cb != cb_q);
  assign flush   = (({{(SUM_W-SIZE_W){1'b0}}, cmd_q.size} + {1'b0, used_q})
                    >= SUM_W'(SLOT_CAPACITY)) || (count_q == CW'(CACHE_ENTRIES));
  assign base_cnt  = flush ? '0 : count_q;
  assign base_used = flush ? '0 : used_q;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    s_d       = s_q;
    rd_vld_d  = 1'b0;
    count_d   = count_q;
    used_d    = used_q;
    cb_d      = cb_q;
    fixed_d   = fixed_q;
    addr_d    = addr_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    pop_o     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = base_cnt[AW-1:0];
    wr_data   = '{idx: cmd_q.idx, addr: base_used[ADDR_W-1:0]};

    unique case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          unique case (cmd_i.op)
            CMD_KEEP: begin
              res_d   = '{changed: 1'b0, fixed_mode: fixed_q, loaded_new: 1'b0,
                          flushed: 1'b0, slot_addr: addr_q, run_callback: 1'b0};
              state_d = B_DONE;
            end
            CMD_FIXED: begin
              fixed_d = 1'b1;
              count_d = '0;
              used_d  = '0;
              cb_d    = '0;
              addr_d  = '0;
              res_d   = '{changed: 1'b1, fixed_mode: 1'b1, loaded_new: 1'b0,
                          flushed: 1'b1, slot_addr: '0, run_callback: 1'b0};
              state_d = B_DONE;
            end
            CMD_CUSTOM: begin
              fixed_d = 1'b0;
              s_d     = '0;
              state_d = B_SEARCH;
            end
            default: begin
              state_d = B_IDLE;
            end
          endcase
        end
      end
      B_SEARCH: begin
        rd_vld_d = issue;
        if (issue) begin
          s_d = s_q + CW'(1);
        end
        if (hit || !issue) begin
          if (hit) begin
            addr_d = rdata_q.addr;
          end else begin
            // miss: append at the used offset, emptying the cache first if needed
            wr_en   = 1'b1;
            count_d = base_cnt + CW'(1);
            used_d  = base_used + {{(USED_W-SIZE_W){1'b0}}, cmd_q.size};
            addr_d  = base_used[ADDR_W-1:0];
          end
          if (run_cb) begin
            cb_d = cmd_q.cb;
          end
          res_d   = '{changed: 1'b1, fixed_mode: 1'b0, loaded_new: !hit,
                      flushed: !hit && flush, slot_addr: addr_d, run_callback: run_cb};
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      rd_vld_q  <= 1'b0;
      count_q   <= '0;
      used_q    <= '0;
      cb_q      <= '0;
      fixed_q   <= 1'b1;
      addr_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      count_q   <= count_d;
      used_q    <= used_d;
      cb_q      <= cb_d;
      fixed_q   <= fixed_d;
      addr_q    <= addr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    s_q   <= s_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

endmodule

>>> design/shader_slot_cache_activator_top.sv
// shader slot cache activator
// req_i (sink): one shader activation request per valid/ready handshake, carrying
//   shader_id (bit 31 marks a custom program), shader_size and callback_id.
// rsp_o (source): exactly one result per request, in request order, with changed,
//   fixed_mode, loaded_new, flushed, slot_addr and run_callback.
// the front stage tracks the active id and classifies each request as unchanged,
//   fixed-function or custom; a two-entry command queue sits between it and the
//   back stage, so requests keep being taken while the back stage works or a
//   result waits in the output register.
// search: a custom request is resolved by scanning the entry memory one read per
//   cycle over the valid entries, bounded by that single read port; unchanged and
//   fixed-function requests skip the scan. The back stage pops the next command
//   only after the last result has been moved into the output register
// reset: the active id is 0x7fffffff, fixed mode is on, the cache is empty and the
//   active address and callback are zero; entry contents are left as they are
// stall: while rsp_o.ready is low the result holds in the output register, the
//   back stage parks with its next result and the queue fills; req_i.ready
//   drops once the queue is full
module shader_slot_cache_activator_top import ssca_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = DEF_CACHE_ENTRIES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssca_req_if.sink   req_i,
  ssca_rsp_if.source rsp_o
);

  // front to queue
  logic         push;
  ssca_cmd_t    push_cmd;
  // queue to back
  logic         pop;
  ssca_cmd_t    pop_cmd;
  ssca_q_stat_t q_stat;

  // front: active id tracking and request classification
  ssca_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // decoupling queue of classified commands
  ssca_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (pop_cmd),
    .q_stat_o (q_stat)
  );

  // back: cache search, load, flush and result register
  ssca_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .cmd_i    (pop_cmd),
    .pop_o    (pop),
    .rsp_o    (rsp_o)
  );

endmodule

>>> design/ssca_checker.sv
`include "shader_slot_cache_activator_top_assert.svh"

module ssca_checker import ssca_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic              changed_i,
  input logic              fixed_mode_i,
  input logic              loaded_new_i,
  input logic              flushed_i,
  input logic [ADDR_W-1:0] slot_addr_i,
  input logic              run_callback_i
);

  `SSCA_ASSERT_NOW(a_fixed_addr_zero, rsp_valid_i && fixed_mode_i, slot_addr_i == '0, "fixed mode with nonzero slot address")

  `SSCA_ASSERT_NOW(a_keep_quiet, rsp_valid_i && !changed_i, !loaded_new_i && !flushed_i && !run_callback_i, "unchanged request reported activity")

  `SSCA_ASSERT_NOW(a_fixed_switch, rsp_valid_i && changed_i && fixed_mode_i, flushed_i && !run_callback_i && !loaded_new_i, "fixed switch without flush")

  `SSCA_ASSERT_NOW(a_custom_flush_loads, rsp_valid_i && flushed_i && !fixed_mode_i, loaded_new_i, "custom flush without load")

  `SSCA_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(slot_addr_i) && $stable(changed_i) && $stable(flushed_i), "stalled result changed")

endmodule

bind shader_slot_cache_activator_top ssca_checker u_ssca_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .changed_i      (rsp_o.changed),
  .fixed_mode_i   (rsp_o.fixed_mode),
  .loaded_new_i   (rsp_o.loaded_new),
  .flushed_i      (rsp_o.flushed),
  .slot_addr_i    (rsp_o.slot_addr),
  .run_callback_i (rsp_o.run_callback)
);
